[sv/ws2812b_pixel_serializer_defines.svh]
// Assertion macros used by the serializer checker.
`ifndef WS2812B_PIXEL_SERIALIZER_DEFINES_SVH
`define WS2812B_PIXEL_SERIALIZER_DEFINES_SVH

// Implication checked on every clock outside reset.
`define WSPS_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("serializer check failed");

// Condition that must hold in the cycle after reset is applied.
`define WSPS_ASSERT_AFTER_RESET(label, cons) \
  label: assert property (@(posedge clk) !rst_n |=> (cons)) \
    else $error("serializer reset check failed");

`endif

[sv/wsps_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package wsps_pkg;

  localparam int TickW  = 10;
  localparam int ColorW = 24;
  localparam int BitsW  = 5;
  localparam int CfgIdxW = 4;

  localparam logic [BitsW-1:0] FrameBits = 5'd24;

  // Operation codes.
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] REG_ZERO_HIGH = 4'd0;
  localparam logic [CfgIdxW-1:0] REG_ZERO_LOW  = 4'd1;
  localparam logic [CfgIdxW-1:0] REG_ONE_HIGH  = 4'd2;
  localparam logic [CfgIdxW-1:0] REG_ONE_LOW   = 4'd3;

  localparam logic [TickW-1:0] ZeroHighRst = 10'd20;
  localparam logic [TickW-1:0] ZeroLowRst  = 10'd43;
  localparam logic [TickW-1:0] OneHighRst  = 10'd40;
  localparam logic [TickW-1:0] OneLowRst   = 10'd22;

  typedef enum logic [1:0] {
    STAT_NONE     = 2'd0,
    STAT_ACCEPTED = 2'd1,
    STAT_RANGE    = 2'd2,
    STAT_BUSY     = 2'd3
  } load_status_t;

  // Classified word passed from front to back.
  typedef struct packed {
    logic                is_tick;
    logic                in_range;
    logic [ColorW-1:0]   grb;
  } cmd_t;

  // Result word.
  typedef struct packed {
    logic         pin_level;
    logic         busy;
    load_status_t status;
    logic         frame_done;
  } res_t;

  typedef struct packed {
    logic [TickW-1:0] zero_high;
    logic [TickW-1:0] zero_low;
    logic [TickW-1:0] one_high;
    logic [TickW-1:0] one_low;
  } cfg_regs_t;

endpackage
`default_nettype wire

[sv/ws2812b_pixel_serializer.sv]
// A word waits in the front queue, is executed, and its result waits in the result queue for pop.
// Throughput: one word per cycle, load or tick, while results are popped; each word passes a
// two-entry front queue and one serializer step that writes a two-entry result queue.
// Reset (synchronous, rst_n low): both queues empty, serializer idle,
// tick registers back to 20, 43, 40 and 22.
`timescale 1ns / 1ps
`default_nettype none
module ws2812b_pixel_serializer (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire                           push,
  output logic                          full,
  input  wire                           in_operation,
  input  wire signed [31:0]             in_color_word,
  output logic                          empty,
  input  wire                           pop,
  output logic                          out_pin_level,
  output logic                          out_busy_res,
  output logic [1:0]                    out_load_status,
  output logic                          out_frame_done,
  input  wire                           cfg_valid,
  output logic                          cfg_ready,
  input  wire  [wsps_pkg::CfgIdxW-1:0]  cfg_index,
  input  wire  [wsps_pkg::TickW-1:0]    cfg_data
);

  wsps_pkg::cmd_t      cmd;
  logic                cmd_valid;
  logic                cmd_take;
  wsps_pkg::cfg_regs_t regs;
  wsps_pkg::res_t      res;

  wsps_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .regs      (regs)
  );

  wsps_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .push          (push),
    .full          (full),
    .in_operation  (in_operation),
    .in_color_word (in_color_word),
    .cmd           (cmd),
    .cmd_valid     (cmd_valid),
    .cmd_take      (cmd_take)
  );

  wsps_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .cmd_valid (cmd_valid),
    .cmd_take  (cmd_take),
    .regs      (regs),
    .res       (res),
    .empty     (empty),
    .pop       (pop)
  );

  assign out_pin_level   = res.pin_level;
  assign out_busy_res    = res.busy;
  assign out_load_status = res.status;
  assign out_frame_done  = res.frame_done;

endmodule
`default_nettype wire

[sv/wsps_cfg.sv]
`timescale 1ns / 1ps
`default_nettype none
module wsps_cfg (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              cfg_valid,
  output logic                             cfg_ready,
  input  wire  [wsps_pkg::CfgIdxW-1:0]     cfg_index,
  input  wire  [wsps_pkg::TickW-1:0]       cfg_data,
  output wsps_pkg::cfg_regs_t              regs
);

  wsps_pkg::cfg_regs_t regs_r, regs_nxt;

  assign cfg_ready = 1'b1;
  assign regs      = regs_r;

  // Decode the register write; unknown indexes are dropped.
  always_comb begin
    regs_nxt = regs_r;
    if (cfg_valid) begin
      case (cfg_index)
        wsps_pkg::REG_ZERO_HIGH: regs_nxt.zero_high = cfg_data;
        wsps_pkg::REG_ZERO_LOW:  regs_nxt.zero_low  = cfg_data;
        wsps_pkg::REG_ONE_HIGH:  regs_nxt.one_high  = cfg_data;
        wsps_pkg::REG_ONE_LOW:   regs_nxt.one_low   = cfg_data;
        default:                 regs_nxt = regs_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.zero_high <= wsps_pkg::ZeroHighRst;
      regs_r.zero_low  <= wsps_pkg::ZeroLowRst;
      regs_r.one_high  <= wsps_pkg::OneHighRst;
      regs_r.one_low   <= wsps_pkg::OneLowRst;
    end else begin
      regs_r <= regs_nxt;
    end
  end

endmodule
`default_nettype wire

[sv/wsps_front.sv]
`timescale 1ns / 1ps
`default_nettype none
module wsps_front (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 push,
  output logic                full,
  input  wire                 in_operation,
  input  wire signed [31:0]   in_color_word,
  output wsps_pkg::cmd_t      cmd,
  output logic                cmd_valid,
  input  wire                 cmd_take
);

  wsps_pkg::cmd_t q_r [2];
  logic           wr_ptr_r, wr_ptr_nxt;
  logic           rd_ptr_r, rd_ptr_nxt;
  logic [1:0]     cnt_r, cnt_nxt;
  wsps_pkg::cmd_t cls;
  logic           do_push;
  logic           do_pop;

  // Classify: range check and reorder to green, red, blue.
  always_comb begin
    cls.is_tick  = (in_operation == wsps_pkg::OP_TICK);
    cls.in_range = (in_color_word[31:24] == 8'h00);
    cls.grb      = {in_color_word[15:8], in_color_word[23:16], in_color_word[7:0]};
  end

  assign full      = (cnt_r == 2'd2);
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd       = q_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = cmd_take && cmd_valid;

  // Advance queue pointers.
  always_comb begin
    wr_ptr_nxt = do_push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Hold the classified word.
  always_ff @(posedge clk) begin
    if (do_push) begin
      q_r[wr_ptr_r] <= cls;
    end
  end

endmodule
`default_nettype wire

[sv/wsps_back.sv]
`timescale 1ns / 1ps
`default_nettype none
module wsps_back (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wsps_pkg::cmd_t         cmd,
  input  wire                    cmd_valid,
  output logic                   cmd_take,
  input  wsps_pkg::cfg_regs_t    regs,
  output wsps_pkg::res_t         res,
  output logic                   empty,
  input  wire                    pop
);

  // Serializer state.
  logic [wsps_pkg::ColorW-1:0] shift_r, shift_nxt;
  logic [wsps_pkg::BitsW-1:0]  bits_r, bits_nxt;
  logic                        low_r, low_nxt;
  logic [wsps_pkg::TickW-1:0]  ticks_r, ticks_nxt;
  logic                        active_r, active_nxt;

  // Result queue.
  wsps_pkg::res_t q_r [2];
  logic           wr_ptr_r, rd_ptr_r;
  logic [1:0]     cnt_r, cnt_nxt;
  logic           do_pop;

  wsps_pkg::res_t             r;
  logic [wsps_pkg::TickW-1:0] lim_raw;
  logic [wsps_pkg::TickW-1:0] lim;
  logic [wsps_pkg::TickW-1:0] ticks_inc;
  logic [wsps_pkg::BitsW-1:0] bits_dec;
  logic                       cur_bit;

  assign cmd_take = cmd_valid && (cnt_r != 2'd2);
  assign empty    = (cnt_r == 2'd0);
  assign res      = q_r[rd_ptr_r];
  assign do_pop   = pop && !empty;

  // Pick the phase length for the current bit; zero acts as one.
  always_comb begin
    cur_bit   = shift_r[wsps_pkg::ColorW-1];
    if (low_r) begin
      lim_raw = cur_bit ? regs.one_low : regs.zero_low;
    end else begin
      lim_raw = cur_bit ? regs.one_high : regs.zero_high;
    end
    lim       = (lim_raw == '0) ? {{(wsps_pkg::TickW-1){1'b0}}, 1'b1} : lim_raw;
    ticks_inc = ticks_r + 1'b1;
    bits_dec  = bits_r - 1'b1;
  end

  // Execute one word.
  always_comb begin
    shift_nxt    = shift_r;
    bits_nxt     = bits_r;
    low_nxt      = low_r;
    ticks_nxt    = ticks_r;
    active_nxt   = active_r;
    r.pin_level  = 1'b0;
    r.busy       = 1'b0;
    r.status     = wsps_pkg::STAT_NONE;
    r.frame_done = 1'b0;
    if (cmd_take) begin
      if (!cmd.is_tick) begin
        if (active_r) begin
          r.status = wsps_pkg::STAT_BUSY;
        end else if (!cmd.in_range) begin
          r.status = wsps_pkg::STAT_RANGE;
        end else begin
          shift_nxt  = cmd.grb;
          bits_nxt   = wsps_pkg::FrameBits;
          low_nxt    = 1'b0;
          ticks_nxt  = '0;
          active_nxt = 1'b1;
          r.status   = wsps_pkg::STAT_ACCEPTED;
        end
        r.busy = active_nxt;
      end else if (active_r) begin
        r.busy      = 1'b1;
        r.pin_level = !low_r;
        ticks_nxt   = ticks_inc;
        if (ticks_inc >= lim || ticks_inc == '0) begin
          ticks_nxt = '0;
          if (!low_r) begin
            low_nxt = 1'b1;
          end else begin
            low_nxt   = 1'b0;
            shift_nxt = {shift_r[wsps_pkg::ColorW-2:0], 1'b0};
            bits_nxt  = bits_dec;
            if (bits_dec == '0) begin
              active_nxt   = 1'b0;
              r.frame_done = 1'b1;
            end
          end
        end
      end
    end
  end

  always_comb begin
    cnt_nxt = cnt_r + {1'b0, cmd_take} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_r  <= '0;
      bits_r   <= '0;
      low_r    <= 1'b0;
      ticks_r  <= '0;
      active_r <= 1'b0;
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      shift_r  <= shift_nxt;
      bits_r   <= bits_nxt;
      low_r    <= low_nxt;
      ticks_r  <= ticks_nxt;
      active_r <= active_nxt;
      wr_ptr_r <= cmd_take ? ~wr_ptr_r : wr_ptr_r;
      rd_ptr_r <= do_pop ? ~rd_ptr_r : rd_ptr_r;
      cnt_r    <= cnt_nxt;
    end
  end

  // Hold the result word until popped.
  always_ff @(posedge clk) begin
    if (cmd_take) begin
      q_r[wr_ptr_r] <= r;
    end
  end

endmodule
`default_nettype wire

[sv/wsps_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
`include "ws2812b_pixel_serializer_defines.svh"
module wsps_checker (
  input wire        clk,
  input wire        rst_n,
  input wire        empty,
  input wire        out_pin_level,
  input wire        out_busy_res,
  input wire [1:0]  out_load_status,
  input wire        out_frame_done
);

  // Result queue starts empty.
  `WSPS_ASSERT_AFTER_RESET(a_empty_after_reset, empty)

  // Frame end is reported inside a busy tick.
  `WSPS_ASSERT_IMPL(a_done_busy, !empty && out_frame_done, out_busy_res)

  // Pin only rises while a frame runs.
  `WSPS_ASSERT_IMPL(a_pin_busy, !empty && out_pin_level, out_busy_res)

  // A load word never drives the pin nor ends a frame.
  `WSPS_ASSERT_IMPL(a_load_quiet, !empty && out_load_status != wsps_pkg::STAT_NONE, !out_pin_level && !out_frame_done)

  // An accepted load leaves the block busy.
  `WSPS_ASSERT_IMPL(a_accept_busy, !empty && out_load_status == wsps_pkg::STAT_ACCEPTED, out_busy_res)

endmodule

bind ws2812b_pixel_serializer wsps_checker u_wsps_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .empty           (empty),
  .out_pin_level   (out_pin_level),
  .out_busy_res    (out_busy_res),
  .out_load_status (out_load_status),
  .out_frame_done  (out_frame_done)
);
`default_nettype wire

[dv/tb_ws2812b_pixel_serializer.sv]
`timescale 1ns / 1ps
module tb_ws2812b_pixel_serializer;
  import wsps_pkg::*;

  localparam int GapMax       = 12;
  localparam int StallCycles  = 96;
  localparam int StallAfter   = 200;
  localparam int QuietLimit   = 4000;
  localparam int RandomWords  = 900;
  localparam int RandomPhases = 6;
  localparam int SettleCycles = 4;
  localparam int TailCycles   = 8;
  localparam int ResetTicks   = 130;

  localparam logic [CfgIdxW-1:0] REG_INDEX_TOP = 4'hF;
  localparam logic [31:0]        ColorMax      = 32'h00FF_FFFF;
  localparam logic [TickW-1:0]   TickMax       = 10'd1023;

  // Track serializer state and queue the expected result words.
  class pixel_scoreboard;
    logic [TickW-1:0]  zero_high, zero_low, one_high, one_low;
    logic [ColorW-1:0] grb;
    logic [BitsW-1:0]  bits_left;
    logic              low_phase;
    logic [TickW-1:0]  phase_ticks;
    logic              active;
    res_t              expected_levels[$];
    int                errors;
    int                loads;
    int                frames;

    function new();
      zero_high   = ZeroHighRst;
      zero_low    = ZeroLowRst;
      one_high    = OneHighRst;
      one_low     = OneLowRst;
      grb         = '0;
      bits_left   = '0;
      low_phase   = 1'b0;
      phase_ticks = '0;
      active      = 1'b0;
      errors      = 0;
      loads       = 0;
      frames      = 0;
    endfunction

    // Indexes past the last register are dropped.
    function void set_reg(logic [CfgIdxW-1:0] idx, logic [TickW-1:0] data);
      case (idx)
        REG_ZERO_HIGH: zero_high = data;
        REG_ZERO_LOW:  zero_low  = data;
        REG_ONE_HIGH:  one_high  = data;
        REG_ONE_LOW:   one_low   = data;
        default: ;
      endcase
    endfunction

    // Ticks in the current phase for this bit; zero counts as one tick.
    function logic [TickW-1:0] phase_length(logic bit_val);
      logic [TickW-1:0] len;
      if (low_phase) begin
        len = bit_val ? one_low : zero_low;
      end else begin
        len = bit_val ? one_high : zero_high;
      end
      return (len == '0) ? TickW'(1) : len;
    endfunction

    function void note_word(logic op, logic [31:0] word);
      res_t             exp;
      logic             bit_val;
      logic [TickW-1:0] limit;
      exp = '0;
      exp.status = STAT_NONE;
      if (op == OP_LOAD) begin
        // Busy check wins over the range check.
        if (active) begin
          exp.status = STAT_BUSY;
        end else if (word > ColorMax) begin
          exp.status = STAT_RANGE;
        end else begin
          grb         = {word[15:8], word[23:16], word[7:0]};
          bits_left   = FrameBits;
          low_phase   = 1'b0;
          phase_ticks = '0;
          active      = 1'b1;
          exp.status  = STAT_ACCEPTED;
          loads++;
        end
        exp.busy = active;
      end else if (active) begin
        bit_val       = grb[ColorW-1];
        limit         = phase_length(bit_val);
        exp.busy      = 1'b1;
        exp.pin_level = !low_phase;
        phase_ticks   = phase_ticks + 1'b1;
        // Advance to the low phase, or to the next bit at the end of it.
        if (phase_ticks >= limit || phase_ticks == '0) begin
          phase_ticks = '0;
          if (!low_phase) begin
            low_phase = 1'b1;
          end else begin
            low_phase = 1'b0;
            grb       = grb << 1;
            bits_left = bits_left - 1'b1;
            if (bits_left == '0) begin
              active         = 1'b0;
              exp.frame_done = 1'b1;
              frames++;
            end
          end
        end
      end
      expected_levels.push_back(exp);
    endfunction

    function void check_word(res_t got);
      res_t exp;
      if (expected_levels.size() == 0) begin
        $error("result word arrived with nothing expected");
        errors++;
        return;
      end
      exp = expected_levels.pop_front();
      if (got.pin_level !== exp.pin_level) begin
        $error("pin_level: expected %0d, got %0d", exp.pin_level, got.pin_level);
        errors++;
      end
      if (got.busy !== exp.busy) begin
        $error("busy_res: expected %0d, got %0d", exp.busy, got.busy);
        errors++;
      end
      if (got.status !== exp.status) begin
        $error("load_status: expected %0d, got %0d", exp.status, got.status);
        errors++;
      end
      if (got.frame_done !== exp.frame_done) begin
        $error("frame_done: expected %0d, got %0d", exp.frame_done, got.frame_done);
        errors++;
      end
    endfunction

    function int pending();
      return expected_levels.size();
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               push = 1'b0;
  logic               full;
  logic               in_operation = OP_TICK;
  logic signed [31:0] in_color_word = '0;
  logic               empty;
  logic               pop = 1'b0;
  logic               out_pin_level;
  logic               out_busy_res;
  logic [1:0]         out_load_status;
  logic               out_frame_done;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [CfgIdxW-1:0] cfg_index = REG_ZERO_HIGH;
  logic [TickW-1:0]   cfg_data = '0;

  pixel_scoreboard sb;
  int              words_sent = 0;
  int              timing_sets = 0;
  int              quiet = 0;
  bit              steady_in = 1'b0;

  ws2812b_pixel_serializer dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .push            (push),
    .full            (full),
    .in_operation    (in_operation),
    .in_color_word   (in_color_word),
    .empty           (empty),
    .pop             (pop),
    .out_pin_level   (out_pin_level),
    .out_busy_res    (out_busy_res),
    .out_load_status (out_load_status),
    .out_frame_done  (out_frame_done),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always #4 clk = ~clk;

  // Offer one word after a random gap and hold it until accepted.
  task automatic send_word(input logic op, input logic [31:0] word);
    int gap;
    gap = steady_in ? 0 : $urandom_range(0, GapMax);
    if ($urandom_range(0, 63) == 0) steady_in = !steady_in;
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push          <= 1'b1;
    in_operation  <= op;
    in_color_word <= word;
    @(posedge clk);
    while (full) @(posedge clk);
    sb.note_word(op, word);
    words_sent++;
  endtask

  // Tick until the frame in flight has ended.
  task automatic drain_frame();
    while (sb.active) send_word(OP_TICK, $urandom);
  endtask

  // Drop push and wait for every expected word to come back.
  task automatic settle();
    push <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [TickW-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_reg(idx, data);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_timing(input logic [TickW-1:0] zh, input logic [TickW-1:0] zl,
                            input logic [TickW-1:0] oh, input logic [TickW-1:0] ol);
    settle();
    write_reg(REG_ZERO_HIGH, zh);
    write_reg(REG_ZERO_LOW, zl);
    write_reg(REG_ONE_HIGH, oh);
    write_reg(REG_ONE_LOW, ol);
    timing_sets++;
  endtask

  // Abort when nothing moves on any channel for too long.
  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
    end
    if (quiet >= QuietLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Pop result words with random gaps and one long hold-off.
  initial begin
    int   gap;
    bit   steady;
    bit   stalled;
    res_t got;
    steady  = 1'b0;
    stalled = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      gap = steady ? 0 : $urandom_range(0, GapMax);
      if ($urandom_range(0, 63) == 0) steady = !steady;
      if (!stalled && words_sent >= StallAfter) begin
        stalled = 1'b1;
        gap     = StallCycles;
      end
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      pop <= 1'b1;
      @(posedge clk);
      while (empty) @(posedge clk);
      got.pin_level  = out_pin_level;
      got.busy       = out_busy_res;
      got.status     = load_status_t'(out_load_status);
      got.frame_done = out_frame_done;
      sb.check_word(got);
    end
  end

  initial begin
    int          word_goal;
    int          pick;
    logic [31:0] word;
    sb = new();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset timing: idle tick, rejected ranges, first bits of a frame, busy loads.
    send_word(OP_TICK, 32'hFFFF_FFFF);
    send_word(OP_LOAD, 32'h8000_0000);
    send_word(OP_LOAD, 32'h7FFF_FFFF);
    send_word(OP_LOAD, 32'h0100_0000);
    send_word(OP_LOAD, 32'hFFFF_FFFF);
    send_word(OP_LOAD, ColorMax);
    send_word(OP_LOAD, 32'h0000_0000);
    send_word(OP_LOAD, 32'h8000_0000);
    repeat (ResetTicks) send_word(OP_TICK, $urandom);

    // Zero counts act as one tick; an unused index is dropped.
    set_timing('0, '0, '0, '0);
    write_reg(REG_INDEX_TOP, TickMax);
    drain_frame();
    send_word(OP_LOAD, 32'h0000_0000);
    send_word(OP_LOAD, 32'h0012_3456);
    drain_frame();

    // Random phases: mostly loads when idle and ticks when busy.
    for (int p = 0; p < RandomPhases; p++) begin
      set_timing(TickW'($urandom_range(0, 4)), TickW'($urandom_range(0, 4)),
                 TickW'($urandom_range(0, 4)), TickW'($urandom_range(0, 4)));
      if ($urandom_range(0, 1) == 1) begin
        write_reg(CfgIdxW'($urandom_range(REG_ONE_LOW + 1, REG_INDEX_TOP)),
                  TickW'($urandom));
      end
      word_goal = words_sent + RandomWords / RandomPhases;
      while (words_sent < word_goal) begin
        pick = $urandom_range(0, 9);
        if (!sb.active) begin
          if (pick < 8) begin
            send_word(OP_LOAD, $urandom & ColorMax);
          end else if (pick == 8) begin
            word = $urandom;
            if (word <= ColorMax) word[31] = 1'b1;
            send_word(OP_LOAD, word);
          end else begin
            send_word(OP_TICK, $urandom);
          end
        end else if (pick < 9) begin
          send_word(OP_TICK, $urandom);
        end else begin
          send_word(OP_LOAD, $urandom);
        end
      end
      drain_frame();
    end

    settle();
    repeat (TailCycles) @(posedge clk);
    $display("Sent %0d words under %0d timing sets plus reset timing", words_sent, timing_sets);
    $display("Accepted %0d color loads, finished %0d frames, %0d mismatches",
             sb.loads, sb.frames, sb.errors);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
